// ----- rtl/nmd_pkg.sv -----
`timescale 1ns / 1ps
// nmd_pkg: shared constants and types for the neighbour-mean denoise core.
// No dependencies; imported by every module of the block.
package nmd_pkg;

    // Fixed field widths
    localparam int COORD_W     = 11;
    localparam int CFG_W       = 12;
    localparam int CFG_INDEX_W = 4;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    // Reset sizes and limits
    localparam int RESET_FRAME_WIDTH  = 1920;
    localparam int RESET_FRAME_HEIGHT = 1080;
    localparam int MIN_FRAME          = 3;

    // Eight neighbours: mean is a shift by three
    localparam int MEAN_SHIFT = 3;

    // Defaults for top-level parameters
    localparam int DEFAULT_MAX_LINE     = 2048;
    localparam int DEFAULT_CHANNEL_BITS = 8;

    // Result queue depth (room for two pushes while draining one)
    localparam int QUEUE_DEPTH = 4;

    // Push request into the result queue
    typedef struct packed {
        logic push_first;
        logic push_second;
    } nmd_push_t;

endpackage

// ----- rtl/nmd_line_buffer.sv -----
`timescale 1ns / 1ps
// nmd_line_buffer: single-port-write, single-port-read synchronous RAM holding
// the two previous lines. Read data is registered. Uses nmd_pkg.
module nmd_line_buffer #(
    parameter int DEPTH  = nmd_pkg::DEFAULT_MAX_LINE,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 6 * nmd_pkg::DEFAULT_CHANNEL_BITS
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);
    import nmd_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read register holds while rd_en is low, so a stalled item keeps its data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/nmd_out_queue.sv -----
`timescale 1ns / 1ps
// nmd_out_queue: small result queue, up to two pushes and one pop per cycle.
// Uses nmd_pkg (QUEUE_DEPTH, nmd_push_t).
module nmd_out_queue #(
    parameter int DATA_W = 2 * nmd_pkg::COORD_W + 3 * nmd_pkg::DEFAULT_CHANNEL_BITS + 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  nmd_pkg::nmd_push_t push,
    input  logic [DATA_W-1:0] first_data,
    input  logic [DATA_W-1:0] second_data,
    output logic              room,
    output logic              head_valid,
    input  logic              head_ready,
    output logic [DATA_W-1:0] head_data
);
    import nmd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;
    logic [1:0]        n_push;

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    // Room for two results regardless of this cycle's pop
    assign room       = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign n_push     = {1'b0, push.push_first} + {1'b0, push.push_second};

    always_comb begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(n_push));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(n_push) - CNT_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push_first) begin
            entry_reg[wr_ptr_reg] <= first_data;
        end
        if (push.push_second) begin
            entry_reg[PTR_W'(wr_ptr_reg + 1'b1)] <= second_data;
        end
    end

endmodule

// ----- rtl/neighbor_mean_denoise_core.sv -----
`timescale 1ns / 1ps
// neighbor_mean_denoise_core: streaming 3x3 neighbour-mean filter, RGB, raster order.
// Depends on nmd_pkg, nmd_line_buffer and nmd_out_queue.

// Pixels enter one item per clock in raster order while the result queue has room.
// Each interior pixel leaves as the per-channel floor mean of its eight neighbours
// (centre excluded); pixels on the outer rows and columns leave as zero with their
// coordinates. An item at (c, r) with c >= 2 and r >= 2 releases interior pixel
// (c-1, r-1); a border item also releases its own zero, right after. Sustained rate
// is one item per cycle, set by the single read and single write per item of the
// line-buffer RAM; where an item raises two results (last column of each line from
// row 2, every column of the last row from column 2) the one-per-cycle result port
// sets the pace, so the last row cannot keep that rate. Results pass the stage A
// registers, then a four-entry result queue that decouples the sides, so input is
// taken while results wait. Line buffers are not cleared after reset; there is no
// clearing pass. The user must make register writes only while idle (the block
// does not enforce it); a size write clamps to 3..MAX_LINE and restarts at (0, 0).
module neighbor_mean_denoise_core #(
    parameter int MAX_LINE     = nmd_pkg::DEFAULT_MAX_LINE,
    parameter int CHANNEL_BITS = nmd_pkg::DEFAULT_CHANNEL_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_we,
    input  logic [nmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nmd_pkg::CFG_W-1:0]       cfg_wdata,
    // pixel input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [CHANNEL_BITS-1:0]         s_pixel_red,
    input  logic [CHANNEL_BITS-1:0]         s_pixel_green,
    input  logic [CHANNEL_BITS-1:0]         s_pixel_blue,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nmd_pkg::COORD_W-1:0]     m_out_col,
    output logic [nmd_pkg::COORD_W-1:0]     m_out_row,
    output logic [CHANNEL_BITS-1:0]         m_out_red,
    output logic [CHANNEL_BITS-1:0]         m_out_green,
    output logic [CHANNEL_BITS-1:0]         m_out_blue,
    output logic                            m_frame_done,
    output logic                            m_run_last
);
    import nmd_pkg::*;

    localparam int CB     = CHANNEL_BITS;
    localparam int POS_W  = $clog2(MAX_LINE);
    localparam int PIX_W  = 3 * CB;
    localparam int LB_W   = 2 * PIX_W;
    localparam int SUM_W  = CB + MEAN_SHIFT;
    localparam int RES_W  = 2 * COORD_W + PIX_W + 2;

    localparam int RST_W  = (RESET_FRAME_WIDTH  > MAX_LINE) ? MAX_LINE : RESET_FRAME_WIDTH;
    localparam int RST_H  = (RESET_FRAME_HEIGHT > MAX_LINE) ? MAX_LINE : RESET_FRAME_HEIGHT;
    localparam logic [POS_W-1:0] RST_W_LAST = POS_W'(RST_W - 1);
    localparam logic [POS_W-1:0] RST_H_LAST = POS_W'(RST_H - 1);

    // ------------------------------------------------------------------
    // Configuration: keep last column / last row of the clamped size
    // ------------------------------------------------------------------
    logic [POS_W-1:0] w_last_reg, h_last_reg;
    logic [31:0]      cfg_size;
    logic [POS_W-1:0] cfg_last;
    logic             cfg_hit;

    always_comb begin
        cfg_size = 32'(cfg_wdata);
        if (cfg_size < 32'(MIN_FRAME)) begin
            cfg_size = 32'(MIN_FRAME);
        end else if (cfg_size > 32'(MAX_LINE)) begin
            cfg_size = 32'(MAX_LINE);
        end
        cfg_last = POS_W'(cfg_size - 32'd1);
        cfg_hit  = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                              (cfg_index == REG_FRAME_HEIGHT));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= RST_W_LAST;
            h_last_reg <= RST_H_LAST;
        end else if (cfg_we) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                w_last_reg <= cfg_last;
            end
            if (cfg_index == REG_FRAME_HEIGHT) begin
                h_last_reg <= cfg_last;
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: position counters, RAM read issue, border flags
    // ------------------------------------------------------------------
    logic             s_fire;
    logic             b_fire;
    logic             q_room;

    logic [POS_W-1:0] col_cnt_reg, col_cnt_next;
    logic [POS_W-1:0] row_cnt_reg, row_cnt_next;

    logic             a_valid_reg;
    logic [PIX_W-1:0] a_pix_reg;      // channel 0 red, 1 green, 2 blue
    logic [POS_W-1:0] a_col_reg;
    logic [POS_W-1:0] a_row_reg;
    logic             a_interior_reg;
    logic             a_border_reg;
    logic             a_done_reg;

    // Stage A drains whenever the queue has room for two results
    assign b_fire  = a_valid_reg && q_room;
    assign s_ready = !a_valid_reg || q_room;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        if (col_cnt_reg == w_last_reg) begin
            col_cnt_next = '0;
            row_cnt_next = (row_cnt_reg == h_last_reg) ? '0 : POS_W'(row_cnt_reg + 1'b1);
        end else begin
            col_cnt_next = POS_W'(col_cnt_reg + 1'b1);
            row_cnt_next = row_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            if (cfg_hit) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= '0;
            end else if (s_fire) begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (s_fire) begin
                a_valid_reg <= 1'b1;
            end else if (b_fire) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_pix_reg      <= {s_pixel_blue, s_pixel_green, s_pixel_red};
            a_col_reg      <= col_cnt_reg;
            a_row_reg      <= row_cnt_reg;
            a_interior_reg <= (col_cnt_reg >= POS_W'(2)) && (row_cnt_reg >= POS_W'(2));
            a_border_reg   <= (col_cnt_reg == '0) || (row_cnt_reg == '0) ||
                              (col_cnt_reg == w_last_reg) || (row_cnt_reg == h_last_reg);
            a_done_reg     <= (col_cnt_reg == w_last_reg) && (row_cnt_reg == h_last_reg);
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: one RAM word per column = {two rows above, row above}.
    // Read at accept, written back when the item leaves stage A. The same
    // column is touched again only a full line later (width >= 3), so read
    // and write never collide and no forwarding is needed.
    // ------------------------------------------------------------------
    logic [LB_W-1:0]  lb_rd_data;
    logic [PIX_W-1:0] above_pix;
    logic [PIX_W-1:0] two_above_pix;

    assign above_pix     = lb_rd_data[PIX_W-1:0];
    assign two_above_pix = lb_rd_data[LB_W-1:PIX_W];

    nmd_line_buffer #(
        .DEPTH  (MAX_LINE),
        .ADDR_W (POS_W),
        .DATA_W (LB_W)
    ) u_line_buffer (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (col_cnt_reg),
        .rd_data (lb_rd_data),
        .wr_en   (b_fire),
        .wr_addr (a_col_reg),
        .wr_data ({above_pix, a_pix_reg})
    );

    // ------------------------------------------------------------------
    // Window: two previous columns of three rows.
    // [0..2] column c-2 (top to bottom), [3..5] column c-1; [4] is the centre.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            for (int k = 0; k < 6; k++) begin
                win_reg[k] <= '0;
            end
        end else if (b_fire) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= two_above_pix;
            win_reg[4] <= above_pix;
            win_reg[5] <= a_pix_reg;
        end
    end

    // Eight-neighbour sum per channel, centre left out
    logic [SUM_W-1:0] ch_sum [3];
    logic [PIX_W-1:0] mean_pix;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ch_sum[i] = SUM_W'(win_reg[0][i*CB +: CB]) + SUM_W'(win_reg[1][i*CB +: CB])
                      + SUM_W'(win_reg[2][i*CB +: CB]) + SUM_W'(win_reg[3][i*CB +: CB])
                      + SUM_W'(win_reg[5][i*CB +: CB]) + SUM_W'(two_above_pix[i*CB +: CB])
                      + SUM_W'(above_pix[i*CB +: CB])  + SUM_W'(a_pix_reg[i*CB +: CB]);
            mean_pix[i*CB +: CB] = ch_sum[i][SUM_W-1:MEAN_SHIFT];
        end
    end

    // ------------------------------------------------------------------
    // Result build: interior result first, border zero second
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] int_col, int_row, bor_col, bor_row;
    logic [RES_W-1:0]   int_res, bor_res, first_res, second_res;
    logic [RES_W-1:0]   head_res;
    logic               both;
    nmd_push_t          push;

    assign int_col = COORD_W'(32'(POS_W'(a_col_reg - 1'b1)));
    assign int_row = COORD_W'(32'(POS_W'(a_row_reg - 1'b1)));
    assign bor_col = COORD_W'(32'(a_col_reg));
    assign bor_row = COORD_W'(32'(a_row_reg));
    assign both    = a_interior_reg && a_border_reg;

    // Packed as {col, row, red, green, blue, frame_done, run_last}
    assign int_res = {int_col, int_row, mean_pix[CB-1:0], mean_pix[2*CB-1:CB],
                      mean_pix[3*CB-1:2*CB], 1'b0, !both};
    assign bor_res = {bor_col, bor_row, {PIX_W{1'b0}}, a_done_reg, 1'b1};

    assign first_res        = a_interior_reg ? int_res : bor_res;
    assign second_res       = bor_res;
    assign push.push_first  = b_fire && (a_interior_reg || a_border_reg);
    assign push.push_second = b_fire && both;

    nmd_out_queue #(
        .DATA_W (RES_W)
    ) u_out_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .first_data  (first_res),
        .second_data (second_res),
        .room        (q_room),
        .head_valid  (m_valid),
        .head_ready  (m_ready),
        .head_data   (head_res)
    );

    assign m_run_last   = head_res[0];
    assign m_frame_done = head_res[1];
    assign m_out_blue   = head_res[2 +: CB];
    assign m_out_green  = head_res[2 + CB +: CB];
    assign m_out_red    = head_res[2 + 2*CB +: CB];
    assign m_out_row    = head_res[2 + PIX_W +: COORD_W];
    assign m_out_col    = head_res[2 + PIX_W + COORD_W +: COORD_W];

endmodule
